>>> src/mdf_pkg.sv
`default_nettype none

package mdf_pkg;

    localparam int unsigned KEY_W          = 64;
    localparam int unsigned OFFSET_W       = 49;
    localparam int unsigned ID_W           = 48;
    localparam int unsigned MID_W          = 31;
    localparam int unsigned TIME_W         = 48;
    localparam int unsigned STEP_W         = 16;
    localparam int unsigned INTERVAL_W     = 32;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned CACHE_DEPTH_DEF = 64;

    localparam logic [KEY_W-1:0] HASH_BASIS     = 64'hCBF2_9CE4_8422_2325;
    // FNV prime is 2^40 + 0x1B3
    localparam int unsigned      PRIME_SHIFT    = 40;
    localparam logic [8:0]       PRIME_LOW      = 9'h1B3;

    localparam logic [STEP_W-1:0]     SAVE_STEP_RST     = 16'd10;
    localparam logic [INTERVAL_W-1:0] SAVE_INTERVAL_RST = 32'd5000000;

    localparam logic REG_SAVE_STEP     = 1'b0;
    localparam logic REG_SAVE_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_FORWARD    = 2'd0,
        VERDICT_STALE      = 2'd1,
        VERDICT_DUPLICATE  = 2'd2,
        VERDICT_NO_MESSAGE = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAVE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;   // start a search: drop all hit flags
        logic shift;   // push the probe key into the head cell
    } chain_ctrl_t;

endpackage

`default_nettype wire

>>> src/mdf_cell.sv
`default_nettype none

module mdf_cell (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire mdf_pkg::chain_ctrl_t     ctrl,
    input  wire [mdf_pkg::KEY_W-1:0]      probe,
    input  wire [mdf_pkg::KEY_W-1:0]      key_in,
    input  wire                           hit_in,
    output logic [mdf_pkg::KEY_W-1:0]     key_out,
    output logic                          hit_out
);

    logic [mdf_pkg::KEY_W-1:0] key_reg, key_next;
    logic                      hit_reg, hit_next;

    always_comb begin
        key_next = ctrl.shift ? key_in : key_reg;
        if (ctrl.clear) begin
            hit_next = 1'b0;
        end else begin
            hit_next = hit_in | (key_reg == probe);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            key_reg <= key_next;
            hit_reg <= hit_next;
        end
    end

    assign key_out = key_reg;
    assign hit_out = hit_reg;

endmodule

`default_nettype wire

>>> src/mdf_key_chain.sv
`default_nettype none

module mdf_key_chain #(
    parameter int unsigned CACHE_DEPTH = mdf_pkg::CACHE_DEPTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire mdf_pkg::chain_ctrl_t     ctrl,
    input  wire [mdf_pkg::KEY_W-1:0]      probe,
    output logic                          hit
);

    logic [mdf_pkg::KEY_W-1:0] key_link [CACHE_DEPTH+1];
    logic                      hit_link [CACHE_DEPTH+1];

    // new keys enter at the head; the oldest falls off the tail
    assign key_link[0] = probe;
    assign hit_link[0] = 1'b0;

    for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
        mdf_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .probe   (probe),
            .key_in  (key_link[i]),
            .hit_in  (hit_link[i]),
            .key_out (key_link[i+1]),
            .hit_out (hit_link[i+1])
        );
    end

    assign hit = hit_link[CACHE_DEPTH];

endmodule

`default_nettype wire

>>> src/message_duplicate_filter.sv
// Duplicate filter for message updates. Chat-id byte items (tuser low) are
// taken one per cycle while the filter is idle, and nonzero bytes fold into an
// FNV-1a 64 hash. A closing item (tuser high) runs the offset update on
// acceptance, the save decision in the next cycle, and, when the message is
// present, not stale and carries a message id, a search in which the hit flag
// walks the key chain one cell per cycle. The result sits in an output
// register, so byte items are taken while it waits. The key cells clear to
// zero directly at reset, with no clearing pass.
`default_nettype none

module message_duplicate_filter #(
    parameter int unsigned CACHE_DEPTH = mdf_pkg::CACHE_DEPTH_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,

    input  wire          cfg_wr_en,
    input  wire          cfg_addr,
    input  wire [mdf_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  wire          s_tvalid,
    output logic         s_tready,
    // chat_byte[7:0], uid_valid[8], uid[56:9], message_present[57],
    // mid_valid[58], mid[89:59], now_us[137:90], zero pad
    input  wire [143:0]  s_tdata,
    // kind[0]
    input  wire          s_tuser,

    output logic         m_tvalid,
    input  wire          m_tready,
    // verdict[1:0], next_offset[50:2], save_request[51], message_key[115:52],
    // zero pad
    output logic [119:0] m_tdata
);

    localparam int unsigned KEY_W  = mdf_pkg::KEY_W;
    localparam int unsigned OFS_W  = mdf_pkg::OFFSET_W;
    localparam int unsigned TIME_W = mdf_pkg::TIME_W;
    localparam int unsigned CNT_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_DEPTH - 1);

    // input fields
    logic [7:0]                   in_byte;
    logic                         in_uid_valid;
    logic [mdf_pkg::ID_W-1:0]     in_uid;
    logic                         in_msg_present;
    logic                         in_mid_valid;
    logic [mdf_pkg::MID_W-1:0]    in_mid;
    logic [TIME_W-1:0]            in_now;

    assign in_byte        = s_tdata[7:0];
    assign in_uid_valid   = s_tdata[8];
    assign in_uid         = s_tdata[56:9];
    assign in_msg_present = s_tdata[57];
    assign in_mid_valid   = s_tdata[58];
    assign in_mid         = s_tdata[89:59];
    assign in_now         = s_tdata[137:90];

    mdf_pkg::state_t state_reg, state_next;

    logic [mdf_pkg::STEP_W-1:0]     step_reg;
    logic [mdf_pkg::INTERVAL_W-1:0] interval_reg;

    logic [KEY_W-1:0]  hash_reg, hash_next;
    logic [OFS_W-1:0]  offset_reg, offset_next;
    logic              saved_valid_reg, saved_valid_next;
    logic [OFS_W-1:0]  saved_reg, saved_next;
    logic [TIME_W-1:0] last_reg, last_next;

    logic              stale_reg, stale_next;
    logic              uid_valid_reg, uid_valid_next;
    logic              msg_reg, msg_next;
    logic              mid_valid_reg, mid_valid_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [KEY_W-1:0]  probe_reg, probe_next;
    logic              save_reg, save_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              m_valid_reg, m_valid_next;
    mdf_pkg::verdict_t out_verdict_reg, out_verdict_next;
    logic [OFS_W-1:0]  out_offset_reg, out_offset_next;
    logic              out_save_reg, out_save_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;

    logic                 accept;
    logic                 out_free;
    logic                 do_search;
    logic                 chain_hit;
    mdf_pkg::chain_ctrl_t chain_ctrl;

    logic [KEY_W-1:0] hash_mix;
    logic [KEY_W-1:0] hash_mul;
    logic [OFS_W-1:0] uid_ext;
    logic [OFS_W-1:0] ofs_diff;
    logic [TIME_W-1:0] time_diff;
    logic             step_hit;
    logic             time_hit;
    logic             save_go;
    logic [KEY_W-1:0] key_build;

    assign accept    = s_tvalid & s_tready;
    assign out_free  = ~m_valid_reg | m_tready;
    assign do_search = ~stale_reg & msg_reg & mid_valid_reg;

    // FNV multiply as a shift and a narrow product
    assign hash_mix = hash_reg ^ {56'd0, in_byte};
    assign hash_mul = (hash_mix << mdf_pkg::PRIME_SHIFT)
                    + (hash_mix * {55'd0, mdf_pkg::PRIME_LOW});

    assign uid_ext   = {1'b0, in_uid};
    assign key_build = (hash_reg << 16)
                     ^ {48'd0, in_mid[15:0]}
                     ^ {1'b0, in_mid, 32'd0};

    assign ofs_diff  = offset_reg - saved_reg;
    assign time_diff = now_reg - last_reg;
    assign step_hit  = (offset_reg >= saved_reg)
                     && (ofs_diff >= {{(OFS_W-mdf_pkg::STEP_W){1'b0}}, step_reg});
    assign time_hit  = (now_reg >= last_reg)
                     && (time_diff >= {{(TIME_W-mdf_pkg::INTERVAL_W){1'b0}}, interval_reg});
    assign save_go   = uid_valid_reg && !stale_reg && (offset_reg != '0)
                     && (!saved_valid_reg || step_hit || time_hit);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mdf_pkg::ST_IDLE: begin
                if (accept && s_tuser) begin
                    state_next = mdf_pkg::ST_SAVE;
                end
            end
            mdf_pkg::ST_SAVE: begin
                state_next = do_search ? mdf_pkg::ST_SEARCH : mdf_pkg::ST_FINISH;
            end
            mdf_pkg::ST_SEARCH: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = mdf_pkg::ST_FINISH;
                end
            end
            mdf_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = mdf_pkg::ST_IDLE;
                end
            end
            default: state_next = mdf_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready         = (state_reg == mdf_pkg::ST_IDLE);
        chain_ctrl.clear = (state_reg == mdf_pkg::ST_SAVE);
        chain_ctrl.shift = 1'b0;

        hash_next        = hash_reg;
        offset_next      = offset_reg;
        saved_valid_next = saved_valid_reg;
        saved_next       = saved_reg;
        last_next        = last_reg;
        stale_next       = stale_reg;
        uid_valid_next   = uid_valid_reg;
        msg_next         = msg_reg;
        mid_valid_next   = mid_valid_reg;
        now_next         = now_reg;
        probe_next       = probe_reg;
        save_next        = save_reg;
        cnt_next         = cnt_reg;

        m_valid_next     = m_valid_reg & ~m_tready;
        out_verdict_next = out_verdict_reg;
        out_offset_next  = out_offset_reg;
        out_save_next    = out_save_reg;
        out_key_next     = out_key_reg;

        unique case (state_reg)
            mdf_pkg::ST_IDLE: begin
                if (accept && !s_tuser) begin
                    if (in_byte != 8'd0) begin
                        hash_next = hash_mul;
                    end
                end else if (accept) begin
                    hash_next      = mdf_pkg::HASH_BASIS;
                    stale_next     = in_uid_valid && (uid_ext < offset_reg);
                    uid_valid_next = in_uid_valid;
                    msg_next       = in_msg_present;
                    mid_valid_next = in_mid_valid;
                    now_next       = in_now;
                    probe_next     = key_build;
                    if (in_uid_valid && !(uid_ext < offset_reg)) begin
                        offset_next = uid_ext + OFS_W'(1);
                    end
                end
            end
            mdf_pkg::ST_SAVE: begin
                save_next = save_go;
                cnt_next  = '0;
                if (save_go) begin
                    saved_next       = offset_reg;
                    saved_valid_next = 1'b1;
                    last_next        = now_reg;
                end
            end
            mdf_pkg::ST_SEARCH: begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            mdf_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_offset_next = offset_reg;
                    out_save_next   = save_reg;
                    out_key_next    = '0;
                    if (stale_reg) begin
                        out_verdict_next = mdf_pkg::VERDICT_STALE;
                    end else if (!msg_reg) begin
                        out_verdict_next = mdf_pkg::VERDICT_NO_MESSAGE;
                    end else if (mid_valid_reg) begin
                        out_key_next = probe_reg;
                        if (chain_hit) begin
                            out_verdict_next = mdf_pkg::VERDICT_DUPLICATE;
                        end else begin
                            out_verdict_next = mdf_pkg::VERDICT_FORWARD;
                            chain_ctrl.shift = 1'b1;
                        end
                    end else begin
                        out_verdict_next = mdf_pkg::VERDICT_FORWARD;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mdf_pkg::ST_IDLE;
            step_reg        <= mdf_pkg::SAVE_STEP_RST;
            interval_reg    <= mdf_pkg::SAVE_INTERVAL_RST;
            hash_reg        <= mdf_pkg::HASH_BASIS;
            offset_reg      <= '0;
            saved_valid_reg <= 1'b0;
            saved_reg       <= '0;
            last_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            hash_reg        <= hash_next;
            offset_reg      <= offset_next;
            saved_valid_reg <= saved_valid_next;
            saved_reg       <= saved_next;
            last_reg        <= last_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mdf_pkg::REG_SAVE_STEP:     step_reg     <= cfg_wdata[15:0];
                    mdf_pkg::REG_SAVE_INTERVAL: interval_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        stale_reg       <= stale_next;
        uid_valid_reg   <= uid_valid_next;
        msg_reg         <= msg_next;
        mid_valid_reg   <= mid_valid_next;
        now_reg         <= now_next;
        probe_reg       <= probe_next;
        save_reg        <= save_next;
        cnt_reg         <= cnt_next;
        out_verdict_reg <= out_verdict_next;
        out_offset_reg  <= out_offset_next;
        out_save_reg    <= out_save_next;
        out_key_reg     <= out_key_next;
    end

    mdf_key_chain #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_key_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (chain_ctrl),
        .probe   (probe_reg),
        .hit     (chain_hit)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, out_key_reg, out_save_reg, out_offset_reg, out_verdict_reg};

endmodule

`default_nettype wire
